### sv/bsf_pkg.sv
package bsf_pkg;

  localparam int HEADER_LEN_DEF = 20;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ADDR_BYTE = 8'hFF;
  localparam logic [7:0] CTRL_BYTE = 8'h03;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] ESC_FLIP  = 8'h20;

  localparam logic [15:0] PROTO_RST = 16'h0021;
  localparam logic        CKW16_RST = 1'b1;

  typedef enum logic [0:0] {
    REG_PROTO = 1'b0,
    REG_CKW16 = 1'b1
  } reg_idx_t;

  // one classified message byte, as queued between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       open;  // frame opens before this byte
    logic       esc;   // byte needs an escape
  } bsf_item_t;

  typedef enum logic [3:0] {
    PH_ENTRY,
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_PHI,
    PH_PLO,
    PH_HDR,
    PH_ESC,
    PH_DATA,
    PH_ZERO,
    PH_CKHI,
    PH_CKLO,
    PH_CLOSE
  } phase_t;

  // fixed header; slots past the table read as zero
  function automatic logic [7:0] hdr_byte(input logic [4:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = 8'hAA;
      5'd1:    b = 8'hBB;
      5'd2:    b = 8'hCC;
      5'd3:    b = 8'h11;
      5'd4:    b = 8'h22;
      5'd5:    b = 8'h33;
      5'd6:    b = 8'hAA;
      5'd7:    b = 8'hEE;
      5'd8:    b = 8'hCC;
      5'd9:    b = 8'h56;
      5'd10:   b = 8'h67;
      5'd11:   b = 8'h33;
      5'd12, 5'd13, 5'd14, 5'd15,
      5'd16, 5'd17, 5'd18, 5'd19: b = 8'h08;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // ones' complement add, 16-bit words
  function automatic logic [15:0] add16(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // ones' complement add, 8-bit words, on the low byte only
  function automatic logic [15:0] add8(input logic [15:0] a, input logic [7:0] b);
    logic [8:0] s;
    logic [7:0] r;
    s = {1'b0, a[7:0]} + {1'b0, b};
    r = s[7:0] + {7'd0, s[8]};
    return {8'h00, r};
  endfunction

endpackage

### sv/bsf_front.sv
module bsf_front import bsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       message_end,
  input  logic       q_full,
  output logic       push,
  output bsf_item_t  item
);

  logic in_frame;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    item.data = data_byte;
    item.last = message_end;
    item.open = !in_frame;
    item.esc  = (data_byte == FLAG_BYTE) || (data_byte == ESC_BYTE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
    end else if (push) begin
      in_frame <= !message_end;
    end
  end

endmodule

### sv/bsf_queue.sv
module bsf_queue import bsf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  bsf_item_t wr_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output bsf_item_t head
);

  bsf_item_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end else begin
        count <= count;
      end
    end
  end

endmodule

### sv/bsf_back.sv
module bsf_back import bsf_pkg::*; #(
  parameter int HEADER_LEN = HEADER_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  bsf_item_t   head,
  output logic        pop,
  input  logic [15:0] protocol_code,
  input  logic        checksum_word_16,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        frame_end
);

  localparam int HCW = (HEADER_LEN > 1) ? $clog2(HEADER_LEN) : 1;
  localparam logic [HCW-1:0] HDR_LAST = HCW'((HEADER_LEN > 0) ? HEADER_LEN - 1 : 0);
  localparam logic [HCW-1:0] HDR_STEP = HCW'(1);

  phase_t         phase, phase_next, cur, data_start;
  logic [HCW-1:0] hdr_cnt, hdr_cnt_next;
  logic [15:0]    sum, sum_next;
  logic           pending, pending_next;
  logic [7:0]     held, held_next;
  logic           advance;

  logic [7:0]     byte_val;
  logic           summed;
  logic           byte_last;
  logic           byte_fe;

  assign advance = head_valid && (!out_valid || out_ready);

  // next state
  always_comb begin
    data_start   = head.esc ? PH_ESC : PH_DATA;
    cur          = (phase == PH_ENTRY) ? (head.open ? PH_FLAG : data_start) : phase;
    phase_next   = phase;
    hdr_cnt_next = hdr_cnt;
    pop          = 1'b0;
    if (advance) begin
      unique case (cur)
        PH_FLAG: phase_next = PH_ADDR;
        PH_ADDR: phase_next = PH_CTRL;
        PH_CTRL: phase_next = PH_PHI;
        PH_PHI:  phase_next = PH_PLO;
        PH_PLO:  phase_next = (HEADER_LEN > 0) ? PH_HDR : data_start;
        PH_HDR: begin
          if (hdr_cnt == HDR_LAST) begin
            phase_next   = data_start;
            hdr_cnt_next = '0;
          end else begin
            hdr_cnt_next = hdr_cnt + HDR_STEP;
          end
        end
        PH_ESC:  phase_next = PH_DATA;
        PH_DATA: begin
          if (head.last) begin
            phase_next = PH_ZERO;
          end else begin
            phase_next = PH_ENTRY;
            pop        = 1'b1;
          end
        end
        PH_ZERO: phase_next = checksum_word_16 ? PH_CKHI : PH_CKLO;
        PH_CKHI: phase_next = PH_CKLO;
        PH_CKLO: phase_next = PH_CLOSE;
        PH_CLOSE: begin
          phase_next = PH_ENTRY;
          pop        = 1'b1;
        end
        default: phase_next = PH_ENTRY;
      endcase
    end
  end

  // byte out of the current phase
  always_comb begin
    byte_val  = ZERO_BYTE;
    summed    = 1'b0;
    byte_last = 1'b0;
    byte_fe   = 1'b0;
    unique case (cur)
      PH_FLAG: byte_val = FLAG_BYTE;
      PH_ADDR: begin
        byte_val = ADDR_BYTE;
        summed   = 1'b1;
      end
      PH_CTRL: begin
        byte_val = CTRL_BYTE;
        summed   = 1'b1;
      end
      PH_PHI: begin
        byte_val = protocol_code[15:8];
        summed   = 1'b1;
      end
      PH_PLO: begin
        byte_val = protocol_code[7:0];
        summed   = 1'b1;
      end
      PH_HDR: begin
        byte_val = hdr_byte(5'(hdr_cnt));
        summed   = 1'b1;
      end
      PH_ESC: begin
        byte_val = ESC_BYTE;
        summed   = 1'b1;
      end
      PH_DATA: begin
        byte_val  = head.esc ? (head.data ^ ESC_FLIP) : head.data;
        summed    = 1'b1;
        byte_last = !head.last;
      end
      PH_ZERO: byte_val = ZERO_BYTE;
      PH_CKHI: byte_val = ~sum[15:8];
      PH_CKLO: byte_val = ~sum[7:0];
      PH_CLOSE: begin
        byte_val  = FLAG_BYTE;
        byte_last = 1'b1;
        byte_fe   = 1'b1;
      end
      default: byte_val = ZERO_BYTE;
    endcase
  end

  // checksum accumulation
  always_comb begin
    sum_next     = sum;
    pending_next = pending;
    held_next    = held;
    priority if (cur == PH_CLOSE) begin
      sum_next     = 16'h0000;
      pending_next = 1'b0;
    end else if (cur == PH_ZERO) begin
      // the 00 byte plus the flush of an odd byte
      if (checksum_word_16) begin
        if (pending) begin
          sum_next = add16(sum, {held, ZERO_BYTE});
        end
      end else begin
        sum_next = pending ? add8(sum, held) : {8'h00, sum[7:0]};
      end
      pending_next = 1'b0;
    end else if (summed) begin
      if (checksum_word_16) begin
        if (pending) begin
          sum_next     = add16(sum, {held, byte_val});
          pending_next = 1'b0;
        end else begin
          held_next    = byte_val;
          pending_next = 1'b1;
        end
      end else begin
        sum_next = add8(sum, byte_val);
      end
    end else begin
      // flag and checksum bytes leave the sum alone
      sum_next = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_ENTRY;
      hdr_cnt <= '0;
      sum     <= 16'h0000;
      pending <= 1'b0;
    end else begin
      phase   <= phase_next;
      hdr_cnt <= hdr_cnt_next;
      if (advance) begin
        sum     <= sum_next;
        pending <= pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held      <= held_next;
      out_byte  <= byte_val;
      run_last  <= byte_last;
      frame_end <= byte_fe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_fe_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_last)
    else $error("closing flag not marked as last byte of its item");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    advance && (cur == PH_CLOSE) |=> (sum == 16'h0000) && !pending)
    else $error("checksum state not cleared after frame close");

  a_hdr_range: assert property (@(posedge clk) disable iff (rst)
    hdr_cnt <= HDR_LAST)
    else $error("header counter out of range");

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && (byte_last || (cur == PH_CLOSE)))
    else $error("queue popped without a finished item");

endmodule

### sv/byte_stuffing_framer_ones_checksum.sv
// Byte-stuffing link framer with ones' complement checksum.
// Input channel (in_valid/in_ready): one message byte per transfer, with
// message_end marking the final byte. A byte arriving with no frame open first
// opens one: flag 7E, FF, 03, protocol code (high byte first), HEADER_LEN
// header bytes. Payload 7E/7D are escaped as 7D 5E / 7D 5D. The final byte is
// followed by 00, the inverted checksum (1 or 2 bytes) and flag 7E.
// Output channel (out_valid/out_ready): one framed byte per transfer;
// run_last marks the last byte caused by an input transfer, frame_end the
// closing flag.
// The first output byte of a transfer passes the queue slot, then the output
// register. Throughput: one output byte per cycle while the queue holds an item
// and out_ready stays high; a mid-frame unescaped byte makes one output byte,
// an escaped one two, a frame-opening byte 5 + HEADER_LEN more,
// a closing byte 3 or 4 more. The output byte sequencer sets this figure.
// A two-entry queue sits between the input side and the sequencer, and the
// output register lets the next byte form while the current one waits.
// Receiver stall: bytes hold in the output register; the queue fills and
// in_ready drops. Reset empties the queue, closes any open frame, clears the
// checksum and restores protocol_code = 0x0021 and 16-bit checksum words.
// Registers (APB): 0x0 protocol_code[15:0], 0x4 checksum_word_16[0].
module byte_stuffing_framer_ones_checksum import bsf_pkg::*; #(
  parameter int HEADER_LEN = HEADER_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        message_end,
  // output byte channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        frame_end,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] protocol_code;
  logic        checksum_word_16;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  bsf_item_t   wr_item;
  bsf_item_t   head;
  logic        push;
  logic        q_full;
  logic        pop;
  logic        head_valid;

  // ---- configuration registers; word index from paddr[2], low bits ignored
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_PROTO: prdata = {16'h0000, protocol_code};
      REG_CKW16: prdata = {31'd0, checksum_word_16};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_code    <= PROTO_RST;
      checksum_word_16 <= CKW16_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PROTO: protocol_code    <= pwdata[15:0];
        REG_CKW16: checksum_word_16 <= pwdata[0];
        default:   protocol_code    <= protocol_code;
      endcase
    end
  end

  // ---- front: take bytes, track frame opening, classify escapes
  bsf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .message_end (message_end),
    .q_full      (q_full),
    .push        (push),
    .item        (wr_item)
  );

  // ---- short queue between front and back
  bsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_item    (wr_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // ---- back: byte sequencer, checksum and output register
  bsf_back #(
    .HEADER_LEN (HEADER_LEN)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .protocol_code    (protocol_code),
    .checksum_word_16 (checksum_word_16),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .run_last         (run_last),
    .frame_end        (frame_end)
  );

endmodule

### sim/testbench.sv
module testbench;
  import bsf_pkg::*;

  // generous ceiling for the whole run
  localparam int CYCLE_LIMIT = 200000;
  // fixed header as it appears on the line, first byte in the top bits
  localparam int HDR_TAB_LEN = 20;
  localparam logic [159:0] HDR_TAB = 160'hAABBCC112233AAEECC5667330808080808080808;

  typedef struct packed {
    logic [7:0] octet;
    logic       run_last;
    logic       frame_end;
  } framed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        message_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        frame_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  byte_stuffing_framer_ones_checksum u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .message_end (message_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .frame_end   (frame_end),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // framer model state: register copies, open frame and running checksum
  logic [15:0] cfg_proto = PROTO_RST;
  logic        cfg_w16 = CKW16_RST;
  logic        frame_open = 1'b0;
  logic [15:0] csum = 16'd0;
  logic        csum_half = 1'b0;
  logic [7:0]  csum_hi = 8'd0;

  // bytes caused by one input transfer, gathered before queuing
  logic [7:0]  burst_oct [0:63];
  logic        burst_fe [0:63];
  int          burst_n = 0;

  // framed bytes still due on the output channel, oldest first
  framed_t     framed_q[$];

  int mismatches = 0;
  int cyc_count = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req = 0;   // long receiver stall asked by a test
  int hold_left = 0;  // cycles of it still to run

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Framer model
  // -------------------------------------------------------------------------

  // ones' complement sums with end-around carry
  function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // 8-bit words only ever touch the low byte of the sum
  function automatic logic [15:0] oc_add8(input logic [15:0] a, input logic [7:0] b);
    logic [8:0] s;
    logic [7:0] r;
    s = {1'b0, a[7:0]} + {1'b0, b};
    r = s[7:0] + {7'd0, s[8]};
    return {8'h00, r};
  endfunction

  // word size is taken per byte, so a mode change mid-frame mixes the two
  function automatic void sum_octet(input logic [7:0] b);
    if (cfg_w16) begin
      if (csum_half) begin
        csum = oc_add16(csum, {csum_hi, b});
        csum_half = 1'b0;
        csum_hi = 8'd0;
      end else begin
        csum_hi = b;
        csum_half = 1'b1;
      end
    end else begin
      csum = oc_add8(csum, b);
    end
  endfunction

  function automatic void put_octet(input logic [7:0] b, input logic fe);
    burst_oct[burst_n] = b;
    burst_fe[burst_n] = fe;
    burst_n++;
  endfunction

  function automatic void put_summed(input logic [7:0] b);
    put_octet(b, 1'b0);
    sum_octet(b);
  endfunction

  // works out every framed byte one message byte causes and queues them
  function automatic void frame_item(input logic [7:0] b, input logic last);
    logic [15:0] inv;
    framed_t     r;
    int          i;
    burst_n = 0;
    if (!frame_open) begin
      // opening: flag, address, control, protocol, fixed header (never stuffed)
      put_octet(FLAG_BYTE, 1'b0);
      put_summed(ADDR_BYTE);
      put_summed(CTRL_BYTE);
      put_summed(cfg_proto[15:8]);
      put_summed(cfg_proto[7:0]);
      for (i = 0; i < HEADER_LEN_DEF; i++)
        put_summed(i < HDR_TAB_LEN ? HDR_TAB[159 - 8 * i -: 8] : ZERO_BYTE);
      frame_open = 1'b1;
    end
    // payload stuffing: flag and escape go out as escape + flipped byte
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      put_summed(ESC_BYTE);
      put_summed(b ^ ESC_FLIP);
    end else begin
      put_summed(b);
    end
    if (last) begin
      put_summed(ZERO_BYTE);
      // an odd byte left over is flushed in the mode current at close
      if (cfg_w16) begin
        if (csum_half)
          csum = oc_add16(csum, {csum_hi, 8'h00});
        inv = ~csum;
        put_octet(inv[15:8], 1'b0);
        put_octet(inv[7:0], 1'b0);
      end else begin
        if (csum_half)
          csum = oc_add8(csum, csum_hi);
        inv = ~csum;
        put_octet(inv[7:0], 1'b0);
      end
      put_octet(FLAG_BYTE, 1'b1);
      frame_open = 1'b0;
      csum = 16'd0;
      csum_half = 1'b0;
      csum_hi = 8'd0;
    end
    for (i = 0; i < burst_n; i++) begin
      r.octet = burst_oct[i];
      r.run_last = (i == burst_n - 1);
      r.frame_end = burst_fe[i];
      framed_q.push_back(r);
    end
  endfunction

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %h, got %h (cycle %0d)", what, want_v, got_v,
               cyc_count);
  endtask

  // every output transfer is held against the oldest framed byte due
  always @(posedge clk) begin
    framed_t want;
    if (!rst && out_valid && out_ready) begin
      if (framed_q.size() == 0) begin
        flag_mismatch("unexpected out_byte", 32'd0, {24'd0, out_byte});
      end else begin
        want = framed_q.pop_front();
        if (out_byte !== want.octet)
          flag_mismatch("out_byte", {24'd0, want.octet}, {24'd0, out_byte});
        if (run_last !== want.run_last)
          flag_mismatch("run_last", {31'd0, want.run_last}, {31'd0, run_last});
        if (frame_end !== want.frame_end)
          flag_mismatch("frame_end", {31'd0, want.frame_end}, {31'd0, frame_end});
      end
    end
  end

  // watchdog: a hung handshake or a missing byte ends the run here
  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random back-pressure, or a long stall when a test asks for one
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // one message byte over the input channel; the model runs on the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    message_end <= last;
    do @(posedge clk); while (!in_ready);
    frame_item(b, last);
  endtask

  // sender goes quiet until the output side has caught up completely
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk);
  endtask

  // setup then access; the register takes the value on the access edge
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_PROTO)
      cfg_proto = v[15:0];
    else
      cfg_w16 = v[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reg_check(input reg_idx_t idx);
    logic [31:0] want_v;
    want_v = (idx == REG_PROTO) ? {16'd0, cfg_proto} : {31'd0, cfg_w16};
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want_v)
      flag_mismatch("prdata", want_v, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // leans on the stuffed values and the all-zero / all-one bytes
  function automatic logic [7:0] rand_octet();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = FLAG_BYTE;
      1: b = ESC_BYTE;
      2: b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  function automatic logic [31:0] rand_proto();
    logic [31:0] p;
    case ($urandom_range(0, 3))
      0: p = 32'h0000;
      1: p = 32'hFFFF;
      default: p = $urandom_range(0, 16'hFFFF);
    endcase
    return p;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // reset values, a one-byte frame, odd and even summed counts, escapes
  task automatic test_reset_defaults();
    reg_check(REG_PROTO);
    reg_check(REG_CKW16);
    send_byte(FLAG_BYTE, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(FLAG_BYTE, 1'b0);
    send_byte(8'h12, 1'b1);
    wait_drained();
  endtask

  // protocol field at both ends and with flag-like bytes (sent unstuffed)
  task automatic test_config_extremes();
    reg_write(REG_PROTO, 32'h0000);
    reg_write(REG_CKW16, 32'd0);
    reg_check(REG_PROTO);
    reg_check(REG_CKW16);
    send_byte(ESC_BYTE, 1'b1);
    wait_drained();
    reg_write(REG_PROTO, 32'hFFFF);
    reg_write(REG_CKW16, 32'd1);
    reg_check(REG_PROTO);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();
    reg_write(REG_PROTO, 32'h7E7D);
    send_byte(8'h55, 1'b1);
    wait_drained();
  endtask

  // word size flipped while a frame is open, a half word held across it
  task automatic test_mode_switch_mid_frame();
    send_byte(8'h11, 1'b0);
    wait_drained();
    reg_write(REG_CKW16, 32'd0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
    send_byte(8'h44, 1'b0);
    wait_drained();
    reg_write(REG_CKW16, 32'd1);
    send_byte(8'h55, 1'b1);
    wait_drained();
  endtask

  // random messages, mostly short, now and then a long one
  task automatic test_random_frames(input int snd_pct, input int rcv_pct, input int n_items);
    int sent;
    int len;
    int k;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    wait_drained();
    reg_write(REG_PROTO, rand_proto());
    reg_write(REG_CKW16, $urandom_range(0, 1));
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (k = 0; k < len && sent < n_items; k++) begin
        send_byte(rand_octet(), (k == len - 1) || (sent == n_items - 1));
        sent++;
      end
    end
    wait_drained();
  endtask

  // receiver blocks for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    int k;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    wait_drained();
    hold_req = 300;
    for (k = 0; k < 14; k++)
      send_byte(rand_octet(), k == 13);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    snd_idle_pct = 17;
    rcv_idle_pct = 60;
    test_reset_defaults();
    test_config_extremes();
    test_mode_switch_mid_frame();

    test_random_frames(17, 60, 80);
    test_random_frames(60, 17, 80);
    test_random_frames(0, 0, 80);
    test_backpressure();

    // allow for a stray byte after the last one due
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && framed_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
